// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the density block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that a condition never occurs.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== src/mvnld_pkg.sv =====
// Types, codes and constants of the multivariate normal log-density block.
`default_nettype none

package mvnld_pkg;

	// Default matrix order
	localparam int MAX_DIMENSION_DEF = 16;

	// Field widths
	localparam int VAL_W = 32;
	localparam int DIFF_W = VAL_W + 1;
	localparam int ACC_W = 48;
	localparam int IDX_W = 4;
	localparam int DIM_REG_W = 5;
	localparam int CFG_IDX_W = 1;

	// Register reset values
	localparam logic [DIM_REG_W-1:0] DIM_RESET = 5'd16;

	// Request type codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DIMENSION_IN_USE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_LOG_DET = 1'b1;

	// One input beat
	typedef struct packed {
		logic req_type;
		logic [IDX_W-1:0] entry_row;
		logic [IDX_W-1:0] entry_column;
		logic signed [VAL_W-1:0] entry_value;
		logic signed [VAL_W-1:0] sample_value;
		logic signed [VAL_W-1:0] mean_value;
	} mvnld_req_t;

	// One result beat
	typedef struct packed {
		logic signed [ACC_W-1:0] log_likelihood;
		logic overflow_flag;
	} mvnld_rsp_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL_A,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ROUND,
		ST_ACC,
		ST_OUT
	} mvnld_state_t;

endpackage

`default_nettype wire

// ===== src/mvnld_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module mvnld_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input wire logic [WIDTH-1:0] wr_data,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== src/mvn_log_density_quadform.sv =====
// Top level of the multivariate normal log-density block (precision form).
`default_nettype none
`include "assert_macros.svh"

// Load beats (req_type 0) write one precision entry and the block stays ready.
// Sample beats (req_type 1) bring one element at a time; element i (from 0)
// has i+1 terms (diagonal first, then cross terms in column order), each of
// which passes through the one shared 32x32 multiplier as read, three
// multiplies, round and accumulate. The last element of a vector then passes
// through an output step that moves the result into the output register; it
// waits there if that register is still full.
// Half the log-determinant seeds the accumulator at element 0; every term is
// subtracted with saturation to 48 bits, which raises overflow_flag.
// Precision entries that were never loaded read back as unknown data.
module mvn_log_density_quadform #(
	parameter int MAX_DIMENSION = mvnld_pkg::MAX_DIMENSION_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	// configuration writes
	input wire logic cfg_wr_en,
	input wire logic [mvnld_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [mvnld_pkg::ACC_W-1:0] cfg_data,
	// request channel
	input wire logic req_valid,
	output logic req_ready,
	input wire mvnld_pkg::mvnld_req_t req,
	// result channel
	output logic rsp_valid,
	input wire logic rsp_ready,
	output mvnld_pkg::mvnld_rsp_t rsp
);

	import mvnld_pkg::*;

	localparam int CNT_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
	localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
	localparam int T_DEPTH = MAX_DIMENSION * MAX_DIMENSION;
	localparam int T_AW = (T_DEPTH > 1) ? $clog2(T_DEPTH) : 1;
	localparam int SUM_W = ACC_W + 2;
	localparam logic [63:0] TERM_CAP = 64'h0001_0000_0000_0000;

	// Configuration registers
	logic [DIM_REG_W-1:0] dim_q;
	logic signed [ACC_W-1:0] hld_q;

	// Sequencer and element state
	mvnld_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] j_q;
	logic diag_q;
	logic [VAL_W-1:0] di_mag_q;
	logic di_neg_q;

	// Datapath registers
	logic [62:0] a_q;
	logic [VAL_W-1:0] b_q;
	logic neg_q;
	logic [63:0] lo_q;
	logic [62:0] ph_q;
	logic [ACC_W:0] mag_q;
	logic signed [ACC_W-1:0] acc_q;
	logic sat_q;

	// Output register
	logic rsp_valid_q;
	mvnld_rsp_t rsp_q;

	// Handshake and control
	logic req_fire, sample_fire, load_fire, load_in_range;
	logic out_free, more_terms, last_elem;
	logic [DIM_W-1:0] dim_eff;

	// Memories
	logic [T_AW-1:0] t_wr_addr, t_rd_addr;
	logic [VAL_W-1:0] t_rd_data;
	logic [DIFF_W-1:0] d_rd_data;
	logic signed [DIFF_W-1:0] d_new;

	// Shared multiplier and term arithmetic
	logic [VAL_W-1:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [VAL_W-1:0] t_mag, dj_mag;
	logic [DIFF_W-1:0] dj_abs;
	logic [63:0] rnd_sum, rnd_val;
	logic rnd_cin;
	logic [SUM_W-1:0] acc_ext, mag_ext, acc_sum;
	logic acc_ovf;
	logic signed [ACC_W-1:0] acc_next;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire = req_valid && req_ready;
	assign sample_fire = req_fire && (req.req_type == REQ_SAMPLE);
	assign load_fire = req_fire && (req.req_type == REQ_LOAD);
	assign load_in_range = (32'(req.entry_row) < MAX_DIMENSION)
		&& (32'(req.entry_column) < MAX_DIMENSION);
	assign out_free = !rsp_valid_q || rsp_ready;

	// Element count in force: zero counts as one, clamp to the matrix order
	always_comb begin
		if (dim_q == '0) begin
			dim_eff = DIM_W'(1);
		end else if (32'(dim_q) > MAX_DIMENSION) begin
			dim_eff = DIM_W'(MAX_DIMENSION);
		end else begin
			dim_eff = DIM_W'(dim_q);
		end
	end

	assign last_elem = (DIM_W'(cnt_q) + DIM_W'(1)) >= dim_eff;
	assign more_terms = diag_q ? (cnt_q != '0)
		: (({1'b0, j_q} + {{CNT_W{1'b0}}, 1'b1}) < {1'b0, cnt_q});

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= DIM_RESET;
			hld_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DIMENSION_IN_USE: dim_q <= cfg_data[DIM_REG_W-1:0];
				REG_HALF_LOG_DET: hld_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Precision matrix store
	assign t_wr_addr = T_AW'(32'(req.entry_row) * MAX_DIMENSION + 32'(req.entry_column));
	assign t_rd_addr = T_AW'(32'(cnt_q) * MAX_DIMENSION + 32'(diag_q ? cnt_q : j_q));

	mvnld_ram #(
		.WIDTH(VAL_W),
		.DEPTH(T_DEPTH)
	) u_prec_ram (
		.clk(clk),
		.wr_en(load_fire && load_in_range),
		.wr_addr(t_wr_addr),
		.wr_data(req.entry_value),
		.rd_addr(t_rd_addr),
		.rd_data(t_rd_data)
	);

	// Difference store, one entry per element position
	assign d_new = DIFF_W'(req.sample_value) - DIFF_W'(req.mean_value);

	mvnld_ram #(
		.WIDTH(DIFF_W),
		.DEPTH(MAX_DIMENSION)
	) u_diff_ram (
		.clk(clk),
		.wr_en(sample_fire),
		.wr_addr(cnt_q),
		.wr_data(d_new),
		.rd_addr(j_q),
		.rd_data(d_rd_data)
	);

	// Magnitudes of the operands read back
	assign t_mag = t_rd_data[VAL_W-1] ? (VAL_W'(0) - t_rd_data) : t_rd_data;
	assign dj_abs = d_rd_data[DIFF_W-1] ? (DIFF_W'(0) - d_rd_data) : d_rd_data;
	assign dj_mag = dj_abs[VAL_W-1:0];

	// Shared multiplier, operands chosen by step
	always_comb begin
		case (state_q)
			ST_MUL_A: begin
				mul_a = di_mag_q;
				mul_b = t_mag;
			end
			ST_MUL_LO: begin
				mul_a = a_q[31:0];
				mul_b = b_q;
			end
			ST_MUL_HI: begin
				mul_a = {1'b0, a_q[62:32]};
				mul_b = b_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

	// Product >> 32 with rounding; halving folds into the carry-in
	assign rnd_cin = diag_q ? 1'b1 : lo_q[31];
	assign rnd_sum = {1'b0, ph_q} + {32'd0, lo_q[63:32]} + {63'd0, rnd_cin};
	assign rnd_val = diag_q ? {1'b0, rnd_sum[63:1]} : rnd_sum;

	// Accumulator minus signed term, saturated to 48 bits
	assign acc_ext = {{2{acc_q[ACC_W-1]}}, acc_q};
	assign mag_ext = {1'b0, mag_q};
	assign acc_sum = neg_q ? (acc_ext + mag_ext) : (acc_ext - mag_ext);
	assign acc_ovf = !((acc_sum[SUM_W-1:ACC_W-1] == '0)
		|| (acc_sum[SUM_W-1:ACC_W-1] == '1));

	always_comb begin
		if (!acc_ovf) begin
			acc_next = acc_sum[ACC_W-1:0];
		end else if (acc_sum[SUM_W-1]) begin
			acc_next = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			acc_next = {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample_fire) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_MUL_A;
			ST_MUL_A: state_d = ST_MUL_LO;
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_ROUND;
			ST_ROUND: state_d = ST_ACC;
			ST_ACC: begin
				if (more_terms) begin
					state_d = ST_READ;
				end else if (last_elem) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Element control and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			j_q <= '0;
			diag_q <= 1'b1;
			acc_q <= '0;
			sat_q <= 1'b0;
		end else begin
			if (sample_fire) begin
				j_q <= '0;
				diag_q <= 1'b1;
				if (cnt_q == '0) begin
					acc_q <= hld_q;
					sat_q <= 1'b0;
				end
			end
			if (state_q == ST_ACC) begin
				acc_q <= acc_next;
				if (acc_ovf) begin
					sat_q <= 1'b1;
				end
				if (diag_q) begin
					diag_q <= 1'b0;
				end else begin
					j_q <= j_q + CNT_W'(1);
				end
				if (!more_terms) begin
					cnt_q <= last_elem ? '0 : (cnt_q + CNT_W'(1));
				end
			end
		end
	end

	// Term datapath, loaded step by step
	always_ff @(posedge clk) begin
		if (sample_fire) begin
			di_mag_q <= d_new[DIFF_W-1] ? VAL_W'(DIFF_W'(0) - d_new) : d_new[VAL_W-1:0];
			di_neg_q <= d_new[DIFF_W-1];
		end
		case (state_q)
			ST_MUL_A: begin
				a_q <= mul_p[62:0];
				b_q <= diag_q ? di_mag_q : dj_mag;
				neg_q <= di_neg_q ^ t_rd_data[VAL_W-1]
					^ (diag_q ? di_neg_q : d_rd_data[DIFF_W-1]);
			end
			ST_MUL_LO: lo_q <= mul_p;
			ST_MUL_HI: ph_q <= mul_p[62:0];
			ST_ROUND: begin
				mag_q <= (rnd_val > TERM_CAP) ? TERM_CAP[ACC_W:0] : rnd_val[ACC_W:0];
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			rsp_q.log_likelihood <= acc_q;
			rsp_q.overflow_flag <= sat_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// Checks
	`ASSERT_CLK(a_sample_starts_seq, sample_fire |=> (state_q == ST_READ), "sample did not start the sequencer")
	`ASSERT_CLK(a_load_stays_idle, load_fire |=> (state_q == ST_IDLE), "load left the idle state")
	`ASSERT_CLK(a_result_waits, (state_q == ST_OUT && rsp_valid && !rsp_ready) |=> (state_q == ST_OUT), "result overwrote a stalled beat")
	`ASSERT_NEVER(a_cross_in_range, (state_q != ST_IDLE && state_q != ST_OUT && !diag_q && !(j_q < cnt_q)), "cross term column not below row")

endmodule

`default_nettype wire

// ===== tb/tb_mvn_log_density_quadform.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the multivariate normal log-density block.
module tb_mvn_log_density_quadform;
	import mvnld_pkg::*;

	localparam int MAX_DIM = MAX_DIMENSION_DEF;
	// Margin for the longest element (16 terms) plus the output move
	localparam int SETTLE_CYCLES = 150;
	localparam int PHASES = 14;
	localparam int PHASE_BEATS = 100;
	localparam int LOAD_PCT = 25;

	localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] Q_ONE = 32'sh0001_0000;
	localparam logic signed [VAL_W-1:0] Q_HALF = 32'sh0000_8000;
	localparam logic signed [VAL_W-1:0] Q_LSB = 32'sh0000_0001;
	localparam logic [ACC_W-1:0] HLD_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [ACC_W-1:0] HLD_MIN = 48'h8000_0000_0000;
	localparam longint ACC_TOP = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ACC_BOTTOM = -64'sh0000_8000_0000_0000;

	// Tracks the block's state and holds the densities still owed
	class density_scoreboard;
		int precision [MAX_DIM][MAX_DIM];
		longint differences [MAX_DIM];
		longint accumulator;
		int unsigned element_index;
		bit saturated;
		logic [DIM_REG_W-1:0] dimension = DIM_RESET;
		longint half_log_det;
		mvnld_rsp_t pending_densities[$];
		int mismatch_count;

		function void write_register(logic [CFG_IDX_W-1:0] index, logic [ACC_W-1:0] data);
			if (index == REG_DIMENSION_IN_USE)
				dimension = data[DIM_REG_W-1:0];
			else if (index == REG_HALF_LOG_DET)
				half_log_det = longint'($signed(data));
		endfunction

		// d_i*T*d_j scaled to Q.16 (halved for the diagonal), rounded on the magnitude
		function longint quadratic_term(longint di, longint t, longint dj, bit halve);
			bit [127:0] prod;
			bit [127:0] hi;
			bit [127:0] r;
			bit negative;
			prod = 128'(di < 0 ? -di : di) * 128'(t < 0 ? -t : t) * 128'(dj < 0 ? -dj : dj);
			hi = prod >> 32;
			if (halve)
				r = (hi >> 1) + hi[0];
			else
				r = hi + (prod[31:0] >= 32'h8000_0000);
			if (r > (128'd1 << ACC_W))
				r = 128'd1 << ACC_W;
			negative = (di < 0) ^ (t < 0) ^ (dj < 0);
			return negative ? -longint'(r[63:0]) : longint'(r[63:0]);
		endfunction

		function void subtract_saturating(longint term);
			longint nxt;
			nxt = accumulator - term;
			if (nxt > ACC_TOP) begin
				nxt = ACC_TOP;
				saturated = 1'b1;
			end
			if (nxt < ACC_BOTTOM) begin
				nxt = ACC_BOTTOM;
				saturated = 1'b1;
			end
			accumulator = nxt;
		endfunction

		// Called for every accepted request beat
		function void note_request(mvnld_req_t beat);
			int unsigned order;
			int unsigned idx;
			longint d;
			mvnld_rsp_t density;
			if (beat.req_type == REQ_LOAD) begin
				precision[beat.entry_row][beat.entry_column] = beat.entry_value;
				return;
			end
			order = (dimension == 0) ? 1 : (dimension > MAX_DIM) ? MAX_DIM : dimension;
			idx = (element_index >= MAX_DIM) ? 0 : element_index;
			if (idx == 0) begin
				accumulator = half_log_det;
				saturated = 1'b0;
			end
			d = longint'($signed(beat.sample_value)) - longint'($signed(beat.mean_value));
			differences[idx] = d;
			// diagonal first, then cross terms by ascending column
			subtract_saturating(quadratic_term(d, precision[idx][idx], d, 1'b1));
			for (int j = 0; j < idx; j++)
				subtract_saturating(quadratic_term(d, precision[idx][j], differences[j], 1'b0));
			if (idx + 1 >= order) begin
				element_index = 0;
				density.log_likelihood = accumulator[ACC_W-1:0];
				density.overflow_flag = saturated;
				pending_densities.push_back(density);
			end else begin
				element_index = idx + 1;
			end
		endfunction

		task report_mismatch(string what);
			if (mismatch_count < 50)
				$display("%0t ns: mismatch: %s", $time, what);
			mismatch_count++;
		endtask

		task check_result(mvnld_rsp_t got);
			mvnld_rsp_t want;
			if (pending_densities.size() == 0) begin
				report_mismatch($sformatf("result beat %h with nothing pending", got));
				return;
			end
			want = pending_densities.pop_front();
			if (got.log_likelihood !== want.log_likelihood)
				report_mismatch($sformatf("log_likelihood %h, expected %h",
					got.log_likelihood, want.log_likelihood));
			if (got.overflow_flag !== want.overflow_flag)
				report_mismatch($sformatf("overflow_flag %b, expected %b",
					got.overflow_flag, want.overflow_flag));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ACC_W-1:0] cfg_data;
	logic req_valid;
	logic req_ready;
	mvnld_req_t req;
	logic rsp_valid;
	logic rsp_ready;
	mvnld_rsp_t rsp;

	density_scoreboard board;
	int idle_pct = 30;
	int wide_pct = 0;

	mvn_log_density_quadform uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly moderate Q16.16 values; wide phases add full-range and rail values
	function automatic logic signed [VAL_W-1:0] random_q16();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < wide_pct / 2)
			return $urandom;
		if (pick < wide_pct) begin
			case ($urandom_range(3))
				0: return Q_MAX;
				1: return Q_MIN;
				2: return '0;
				default: return -Q_LSB;
			endcase
		end
		return $signed($urandom_range(0, 32'h10_0000)) - 32'sh8_0000;
	endfunction

	// Present one request beat; valid stays up for a following beat
	task automatic send_beat(input mvnld_req_t beat);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= beat;
		do @(posedge clk); while (req_ready !== 1'b1);
		board.note_request(beat);
	endtask

	task automatic load_entry(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] column,
			input logic signed [VAL_W-1:0] value);
		mvnld_req_t beat;
		beat.req_type = REQ_LOAD;
		beat.entry_row = row;
		beat.entry_column = column;
		beat.entry_value = value;
		beat.sample_value = $urandom;
		beat.mean_value = $urandom;
		send_beat(beat);
	endtask

	task automatic sample_element(input logic signed [VAL_W-1:0] observed,
			input logic signed [VAL_W-1:0] mean);
		mvnld_req_t beat;
		beat.req_type = REQ_SAMPLE;
		beat.entry_row = IDX_W'($urandom);
		beat.entry_column = IDX_W'($urandom);
		beat.entry_value = $urandom;
		beat.sample_value = observed;
		beat.mean_value = mean;
		send_beat(beat);
	endtask

	// Drop valid, drain owed densities, then let an in-flight element finish
	task automatic settle();
		req_valid <= 1'b0;
		while (board.pending_densities.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [ACC_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		board.write_register(index, data);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: random back-pressure, check every accepted beat
	initial begin
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_ready === 1'b1)
				board.check_result(rsp);
			rsp_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// Stimulus
	initial begin
		logic [DIM_REG_W-1:0] dim;
		logic [63:0] wide;
		logic [ACC_W-1:0] hld;
		board = new;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every entry that is ever read gets written before any sample
		for (int r = 0; r < MAX_DIM; r++)
			for (int c = 0; c <= r; c++)
				load_entry(IDX_W'(r), IDX_W'(c), random_q16());

		// order 1: both rails, half-LSB rounding, zero difference
		settle();
		write_reg(REG_DIMENSION_IN_USE, ACC_W'(1));
		write_reg(REG_HALF_LOG_DET, '0);
		load_entry(0, 0, Q_MAX);
		sample_element(Q_MAX, Q_MIN);
		load_entry(0, 0, Q_MIN);
		sample_element(Q_MIN, Q_MAX);
		load_entry(0, 0, Q_LSB);
		sample_element(Q_ONE, '0);
		sample_element(Q_MAX, Q_MAX);

		// half log-determinant at its rails
		load_entry(0, 0, Q_ONE);
		settle();
		write_reg(REG_HALF_LOG_DET, HLD_MAX);
		sample_element(Q_ONE, '0);
		load_entry(0, 0, -Q_ONE);
		sample_element('0, Q_ONE);
		settle();
		write_reg(REG_HALF_LOG_DET, HLD_MIN);
		sample_element(Q_ONE, '0);
		load_entry(0, 0, Q_ONE);
		sample_element(Q_ONE, '0);

		// order 2: cross term at exactly half an LSB; upper triangle is never read
		settle();
		write_reg(REG_DIMENSION_IN_USE, ACC_W'(2));
		write_reg(REG_HALF_LOG_DET, '0);
		load_entry(1, 0, Q_LSB);
		load_entry(1, 1, '0);
		load_entry(0, 0, '0);
		load_entry(0, 1, Q_MAX);
		load_entry(15, 15, random_q16());
		load_entry(15, 0, random_q16());
		sample_element(Q_ONE, '0);
		sample_element(Q_HALF, '0);

		// order lowered mid-vector: the vector ends on the next element
		settle();
		write_reg(REG_DIMENSION_IN_USE, ACC_W'(3));
		sample_element(random_q16(), random_q16());
		sample_element(random_q16(), random_q16());
		settle();
		write_reg(REG_DIMENSION_IN_USE, ACC_W'(2));
		sample_element(random_q16(), random_q16());

		// random phases, each with its own order and log-determinant
		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			idle_pct = (phase == 2 || phase == 3) ? 0 : 30;
			wide_pct = (phase % 2 == 1) ? 8 : 0;
			case (phase)
				0: dim = 31;
				1: dim = 0;
				2: dim = 16;
				3: dim = 1;
				4: dim = 2;
				5: dim = 16;
				default: dim = DIM_REG_W'($urandom_range(0, 31));
			endcase
			wide = {$urandom, $urandom};
			write_reg(REG_DIMENSION_IN_USE, {wide[ACC_W-1:DIM_REG_W], dim});
			wide = {$urandom, $urandom};
			if (phase == 6)
				hld = HLD_MAX;
			else if (phase == 7)
				hld = HLD_MIN;
			else if (wide_pct != 0)
				hld = wide[ACC_W-1:0];
			else
				hld = {{11{wide[36]}}, wide[36:0]};
			write_reg(REG_HALF_LOG_DET, hld);
			for (int k = 0; k < PHASE_BEATS; k++) begin
				if ($urandom_range(99) < LOAD_PCT)
					load_entry(IDX_W'($urandom), IDX_W'($urandom), random_q16());
				else
					sample_element(random_q16(), random_q16());
			end
		end

		idle_pct = 30;
		settle();
		if (board.mismatch_count == 0 && board.pending_densities.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
